// ===== sv/paddle_timer_game_port_macros.svh =====
// Assertion helpers shared by the game port RTL.
// Both sample on clock and are switched off while reset is high.
`ifndef PADDLE_TIMER_GAME_PORT_MACROS_SVH
`define PADDLE_TIMER_GAME_PORT_MACROS_SVH

// Same-cycle implication.
`define PTGP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptgp: assertion failed");

// Next-cycle implication.
`define PTGP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptgp: assertion failed");

`endif

// ===== sv/ptgp_pkg.sv =====
`timescale 1ns / 1ps

package ptgp_pkg;

   // Paddle timers actually built (1..4); the address map always has 4 slots.
   localparam int NumPaddles     = 4;
   localparam int PaddleSlots    = 4;
   localparam int SlotSelWidth   = $clog2(PaddleSlots);

   localparam int AddrWidth      = 16;
   localparam int CycleWidth     = 32;
   localparam int ButtonCount    = 3;
   localparam int AxisWidth      = 16;
   localparam int ScaleWidth     = 16;
   localparam int LevelWidth     = 8;
   localparam int ProductWidth   = LevelWidth + ScaleWidth;
   localparam int SpanWidth      = 16;
   localparam int DataWidth      = 8;

   localparam logic [ScaleWidth-1:0] FullScaleReset = 16'd2816;
   localparam logic [DataWidth-1:0]  StatusByte     = 8'h80;
   localparam logic [7:0]            AddrButton0    = 8'h61;
   localparam logic [7:0]            AddrButtonLast = 8'h63;
   localparam logic [7:0]            AddrPaddle0    = 8'h64;
   localparam logic [7:0]            AddrPaddleLast = 8'h67;
   localparam logic [7:0]            AddrTrigger    = 8'h70;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_BUTTON,
      OP_PADDLE,
      OP_TRIGGER
   } op_type;

   typedef struct packed {
      logic                  load;
      logic [CycleWidth-1:0] now;
   } bank_ctl_type;

endpackage

// ===== sv/ptgp_lane_scale.sv =====
`timescale 1ns / 1ps

// Axis position to level 0..254, then times the full-scale cycle count.
module ptgp_lane_scale import ptgp_pkg::*; (
   input  logic signed [AxisWidth-1:0] axis,
   input  logic [ScaleWidth-1:0]       scale,
   output logic [ProductWidth-1:0]     product
);

   logic [AxisWidth-1:0]      biased;
   logic [AxisWidth+7:0]      times255;
   logic [LevelWidth-1:0]     level;

   // level = (biased * 255) >> 16, with 255 = 256 - 1
   assign biased   = AxisWidth'(axis) ^ {1'b1, {(AxisWidth-1){1'b0}}};
   assign times255 = {biased, 8'h00} - {8'h00, biased};
   assign level    = times255[AxisWidth+7:AxisWidth];

   // 254 * 65535 fits the product width
   assign product  = ProductWidth'(level) * ProductWidth'(scale);

endmodule

// ===== sv/ptgp_div255.sv =====
`timescale 1ns / 1ps

// Exact floor(x / 255) for x < 2^24: x * 0x01010102 >> 32, as shifts and adds.
module ptgp_div255 import ptgp_pkg::*; (
   input  logic [ProductWidth-1:0] dividend,
   output logic [SpanWidth-1:0]    quotient
);

   localparam int SumWidth = ProductWidth + 25;

   logic [SumWidth-1:0] wide;
   logic [SumWidth-1:0] sum;

   assign wide     = SumWidth'(dividend);
   assign sum      = (wide << 24) + (wide << 16) + (wide << 8) + (wide << 1);
   assign quotient = sum[32 +: SpanWidth];

endmodule

// ===== sv/ptgp_timer_bank.sv =====
`timescale 1ns / 1ps
`include "paddle_timer_game_port_macros.svh"

// Paddle deadline registers and their running compare.
module ptgp_timer_bank import ptgp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  bank_ctl_type           ctl,
   input  logic [SpanWidth-1:0]   span [NumPaddles],
   output logic [PaddleSlots-1:0] busy
);

   logic [CycleWidth-1:0] deadline_ff [NumPaddles];
   logic [CycleWidth-1:0] deadline_in [NumPaddles];

   always_comb begin
      busy = '0;
      for (int i = 0; i < NumPaddles; i++) begin
         deadline_in[i] = ctl.now + CycleWidth'(span[i]);
         busy[i]        = ctl.now < deadline_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumPaddles; i++) begin
            deadline_ff[i] <= '0;
         end
      end else if (ctl.load) begin
         for (int i = 0; i < NumPaddles; i++) begin
            deadline_ff[i] <= deadline_in[i];
         end
      end
   end

   `PTGP_ASSERT_NEXT(a_load_sum, ctl.load, deadline_ff[0] == $past(ctl.now + CycleWidth'(span[0])))
   `PTGP_ASSERT_NEXT(a_hold_idle, !ctl.load, $stable(deadline_ff[0]))

endmodule

// ===== sv/paddle_timer_game_port.sv =====
`timescale 1ns / 1ps
`include "paddle_timer_game_port_macros.svh"

// Game I/O port with three push buttons and paddle one-shot timers. Every
// request transfer is one bus access and yields exactly one response transfer
// carrying a status byte: 0x61-0x63 read a button (0x00 held, 0x80 released),
// 0x64-0x67 read a paddle timer (0x80 while cycle_count is below its deadline,
// unsigned), 0x70 restarts every timer at cycle_count + level*scale/255 and
// returns 0x00, anything else returns 0x00. Only the low address byte counts.
// Throughput is one transfer per clock unless rsp_stall holds the pipe; a
// request passes four register stages before its response is valid: input
// capture, axis-level multiply, divide by 255, and deadline add/compare plus
// the response register. Timer loads and timer reads both happen in the last
// stage, so a read right behind a restart sees the new deadlines. The scale
// register is taken on any csr transfer (csr_ready is tied high) and should
// only change while no request is in flight.
module paddle_timer_game_port import ptgp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [AddrWidth-1:0]        req_address,
   input  logic [CycleWidth-1:0]       req_cycle_count,
   input  logic [ButtonCount-1:0]      req_buttons_pressed,
   input  logic signed [AxisWidth-1:0] req_axis_zero,
   input  logic signed [AxisWidth-1:0] req_axis_one,
   input  logic signed [AxisWidth-1:0] req_axis_two,
   input  logic signed [AxisWidth-1:0] req_axis_three,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [DataWidth-1:0]        rsp_read_data,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ScaleWidth-1:0]       csr_full_scale_cycles
);

   // ---------------------------------------------------------------
   // Scale register
   // ---------------------------------------------------------------
   logic [ScaleWidth-1:0] scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= FullScaleReset;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_full_scale_cycles;
      end
   end

   // ---------------------------------------------------------------
   // Flow control: each stage moves when the one after it has room
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, rsp_valid_in;
   logic out_ready, s3_ready, s2_ready, s1_ready;
   logic req_accept, s3_adv;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign s3_adv     = s3_valid_ff && out_ready;

   assign s1_valid_in  = s1_ready  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready  ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = out_ready ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: address decode and capture
   // ---------------------------------------------------------------
   logic [7:0]              sel;
   op_type                  op_in;
   logic [SlotSelWidth-1:0] idx_in;

   assign sel = req_address[7:0];

   always_comb begin
      op_in  = OP_NONE;
      idx_in = sel[SlotSelWidth-1:0];
      priority if (sel >= AddrButton0 && sel <= AddrButtonLast) begin
         op_in  = OP_BUTTON;
         idx_in = SlotSelWidth'(sel - AddrButton0);
      end else if (sel >= AddrPaddle0 && sel <= AddrPaddleLast) begin
         op_in  = OP_PADDLE;
         idx_in = SlotSelWidth'(sel - AddrPaddle0);
      end else if (sel == AddrTrigger) begin
         op_in  = OP_TRIGGER;
      end else begin
         // undecoded byte: plain zero response
         op_in  = OP_NONE;
      end
   end

   op_type                      s1_op_ff;
   logic [SlotSelWidth-1:0]     s1_idx_ff;
   logic [CycleWidth-1:0]       s1_now_ff;
   logic [ButtonCount-1:0]      s1_buttons_ff;
   logic signed [AxisWidth-1:0] s1_axis_ff [PaddleSlots];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= op_in;
         s1_idx_ff     <= idx_in;
         s1_now_ff     <= req_cycle_count;
         s1_buttons_ff <= req_buttons_pressed;
         s1_axis_ff[0] <= req_axis_zero;
         s1_axis_ff[1] <= req_axis_one;
         s1_axis_ff[2] <= req_axis_two;
         s1_axis_ff[3] <= req_axis_three;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: level times scale, one multiplier per paddle
   // ---------------------------------------------------------------
   logic [ProductWidth-1:0] product_in [NumPaddles];

   for (genvar g = 0; g < NumPaddles; g++) begin : g_scale
      ptgp_lane_scale u_scale (
         .axis    (s1_axis_ff[g]),
         .scale   (scale_ff),
         .product (product_in[g])
      );
   end

   op_type                  s2_op_ff;
   logic [SlotSelWidth-1:0] s2_idx_ff;
   logic [CycleWidth-1:0]   s2_now_ff;
   logic [ButtonCount-1:0]  s2_buttons_ff;
   logic [ProductWidth-1:0] s2_product_ff [NumPaddles];

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_op_ff      <= s1_op_ff;
         s2_idx_ff     <= s1_idx_ff;
         s2_now_ff     <= s1_now_ff;
         s2_buttons_ff <= s1_buttons_ff;
         s2_product_ff <= product_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: divide by 255
   // ---------------------------------------------------------------
   logic [SpanWidth-1:0] span_in [NumPaddles];

   for (genvar g = 0; g < NumPaddles; g++) begin : g_div
      ptgp_div255 u_div (
         .dividend (s2_product_ff[g]),
         .quotient (span_in[g])
      );
   end

   op_type                  s3_op_ff;
   logic [SlotSelWidth-1:0] s3_idx_ff;
   logic [CycleWidth-1:0]   s3_now_ff;
   logic [ButtonCount-1:0]  s3_buttons_ff;
   logic [SpanWidth-1:0]    s3_span_ff [NumPaddles];

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_op_ff      <= s2_op_ff;
         s3_idx_ff     <= s2_idx_ff;
         s3_now_ff     <= s2_now_ff;
         s3_buttons_ff <= s2_buttons_ff;
         s3_span_ff    <= span_in;
      end
   end

   // ---------------------------------------------------------------
   // Last stage: timer load/compare and response byte
   // ---------------------------------------------------------------
   bank_ctl_type           bank_ctl;
   logic [PaddleSlots-1:0] busy;

   assign bank_ctl.load = s3_adv && (s3_op_ff == OP_TRIGGER);
   assign bank_ctl.now  = s3_now_ff;

   ptgp_timer_bank u_bank (
      .clock (clock),
      .reset (reset),
      .ctl   (bank_ctl),
      .span  (s3_span_ff),
      .busy  (busy)
   );

   // pad the button vector to the index range; the pad is never selected
   logic [PaddleSlots-1:0] button_vec;
   logic [DataWidth-1:0]   rsp_read_data_in;
   logic [DataWidth-1:0]   rsp_read_data_ff;

   assign button_vec = {{(PaddleSlots-ButtonCount){1'b1}}, s3_buttons_ff};

   always_comb begin
      unique case (s3_op_ff)
         OP_BUTTON:  rsp_read_data_in = button_vec[s3_idx_ff] ? '0 : StatusByte;
         OP_PADDLE:  rsp_read_data_in = busy[s3_idx_ff] ? StatusByte : '0;
         OP_TRIGGER: rsp_read_data_in = '0;
         default:    rsp_read_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_read_data_ff <= rsp_read_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

   `PTGP_ASSERT_NEXT(a_s3_to_rsp, s3_adv, rsp_valid_ff)
   `PTGP_ASSERT_NOW(a_rsp_byte, rsp_valid_ff, (rsp_read_data_ff == StatusByte) || (rsp_read_data_ff == '0))
   `PTGP_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s2_ready, s1_valid_ff && $stable(s1_now_ff))

endmodule
